[hdl/sound_dsp_command_port_defines.svh]
// Assertion macros shared by the command port modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SOUND_DSP_COMMAND_PORT_DEFINES_SVH
`define SOUND_DSP_COMMAND_PORT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SDCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sdcp_pkg.sv]
// Shared types, codes and helper functions of the DSP command port.
// No dependencies; used by sdcp_ctrl, sdcp_dp and the top level.
package sdcp_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input item
    logic commit;   // apply the item and load the result register
  } ctrl_cmd_t;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_DMA   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DMA_BLOCK_LEN = 1'b0;
  localparam logic CFG_AUDIO_READY   = 1'b1;

  // I/O ports.
  localparam logic [9:0] PORT_RESET  = 10'h226;
  localparam logic [9:0] PORT_CMD    = 10'h22c;
  localparam logic [9:0] PORT_READ   = 10'h22a;
  localparam logic [9:0] PORT_STATUS = 10'h22e;

  // Opcodes.
  localparam logic [7:0] OP_DMA8      = 8'h14;
  localparam logic [7:0] OP_TIME_CONST = 8'h40;
  localparam logic [7:0] OP_HALT      = 8'hD0;
  localparam logic [7:0] OP_IDENT     = 8'hE0;
  localparam logic [7:0] OP_VERSION   = 8'hE1;
  localparam logic [3:0] OP_GEN8_HI   = 4'hB;
  localparam logic [3:0] OP_GEN16_HI  = 4'hC;

  localparam logic [7:0]  AUTODETECT   = 8'haa;
  localparam logic [7:0]  STATUS_READY = 8'h80;
  localparam logic [15:0] RATE_RESET   = 16'd22050;
  localparam logic [10:0] MAX_BLOCK    = 11'd1024;
  localparam int          TcClock      = 1000000;

  // A time constant tc gives rate TcClock/(256-tc). The rate exceeds a bound T
  // exactly when 256-tc <= TcClock/(T+1), so each snap bound becomes a
  // minimum time constant.
  localparam logic [8:0] TC_MIN_48000 = 9'(256 - TcClock / (46050 + 1));
  localparam logic [8:0] TC_MIN_44100 = 9'(256 - TcClock / (38050 + 1));
  localparam logic [8:0] TC_MIN_32000 = 9'(256 - TcClock / (28000 + 1));
  localparam logic [8:0] TC_MIN_24000 = 9'(256 - TcClock / (23025 + 1));
  localparam logic [8:0] TC_MIN_22050 = 9'(256 - TcClock / (19025 + 1));
  localparam logic [8:0] TC_MIN_16000 = 9'(256 - TcClock / (14000 + 1));
  localparam logic [8:0] TC_MIN_12000 = 9'(256 - TcClock / (11512 + 1));
  localparam logic [8:0] TC_MIN_11025 = 9'(256 - TcClock / (9512 + 1));

  function automatic logic [15:0] snap_rate(input logic [7:0] tc);
    logic [8:0] t;
    t = {1'b0, tc};
    if (t >= TC_MIN_48000) return 16'd48000;
    else if (t >= TC_MIN_44100) return 16'd44100;
    else if (t >= TC_MIN_32000) return 16'd32000;
    else if (t >= TC_MIN_24000) return 16'd24000;
    else if (t >= TC_MIN_22050) return 16'd22050;
    else if (t >= TC_MIN_16000) return 16'd16000;
    else if (t >= TC_MIN_12000) return 16'd12000;
    else if (t >= TC_MIN_11025) return 16'd11025;
    else return 16'd8000;
  endfunction

  // Bytes that follow an opcode, the opcode itself not counted.
  function automatic logic [1:0] needed_bytes(input logic [7:0] op);
    if (op == OP_TIME_CONST || op == OP_IDENT) return 2'd1;
    else if (op == OP_DMA8) return 2'd2;
    else if (op[7:4] == OP_GEN8_HI || op[7:4] == OP_GEN16_HI) return 2'd3;
    else return 2'd0;
  endfunction

endpackage

[hdl/sdcp_ctrl.sv]
// Controller of the DSP command port: item handshake and result register valid.
// Depends on sdcp_pkg and sound_dsp_command_port_defines.svh.
`include "sound_dsp_command_port_defines.svh"

module sdcp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output sdcp_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register is free when empty or when its transfer completes now.
  assign out_free    = !out_valid_r || !out_stall;
  assign cmd.capture = in_valid && (state_r == ST_IDLE);
  assign cmd.commit  = (state_r == ST_EXEC) && out_free;
  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SDCP_ASSERT_NEXT(a_accept_execs, clk, rst_n, in_valid && !in_stall, state_r == ST_EXEC,
    "accepted item did not enter execution")
  `SDCP_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_r,
    "committed result is not presented")
  `SDCP_ASSERT_NEXT(a_no_overwrite, clk, rst_n,
    state_r == ST_EXEC && out_valid_r && out_stall, state_r == ST_EXEC && out_valid_r,
    "pending result overwritten or dropped")

endmodule

[hdl/sdcp_dp.sv]
// Datapath of the DSP command port: parser state, out buffer, DMA counter,
// rate snap and the result register. Depends on sdcp_pkg and the defines header.
`include "sound_dsp_command_port_defines.svh"

module sdcp_dp #(
  parameter int OUT_DEPTH = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdcp_pkg::ctrl_cmd_t cmd,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data,
  input  logic [1:0]          in_kind,
  input  logic [9:0]          in_port,
  input  logic [7:0]          in_data,
  input  logic [10:0]         in_transfer_len,
  output logic [7:0]          out_read_data,
  output logic                out_dma_active,
  output logic [16:0]         out_samples_left,
  output logic [10:0]         out_dma_request_len,
  output logic [15:0]         out_sample_rate,
  output logic                out_wide_samples
);

  localparam int FILL_W = $clog2(OUT_DEPTH + 1);
  localparam int IDX_W  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(OUT_DEPTH);

  // Captured item.
  logic [1:0]  kind_r;
  logic [9:0]  port_r;
  logic [7:0]  data_r;
  logic [10:0] tlen_r;

  // Configuration.
  logic [10:0] blk_len_r;
  logic        audio_ready_r;

  // Architectural state.
  logic              cmd_pending_r, cmd_pending_nxt;
  logic [7:0]        cur_opcode_r, cur_opcode_nxt;
  logic [1:0]        param_fill_r, param_fill_nxt;
  logic [7:0]        param_bytes_r [3];
  logic [7:0]        param_bytes_nxt [3];
  logic [7:0]        out_bytes_r [OUT_DEPTH];
  logic [7:0]        out_bytes_nxt [OUT_DEPTH];
  logic [FILL_W-1:0] out_fill_r, out_fill_nxt;
  logic [16:0]       dma_count_r, dma_count_nxt;
  logic              dma_on_r, dma_on_nxt;
  logic [15:0]       rate_r, rate_nxt;
  logic              wide_r, wide_nxt;

  // Result register.
  logic [7:0]  rd_r, rd_nxt;
  logic [10:0] req_r, req_nxt;

  logic [7:0]        op;
  logic [1:0]        pf;
  logic [FILL_W-1:0] pop_pos;
  logic [16:0]       moved;
  logic [10:0]       blk;

  assign pop_pos = out_fill_r - FILL_W'(1);

  always_comb begin
    cmd_pending_nxt = cmd_pending_r;
    cur_opcode_nxt  = cur_opcode_r;
    param_fill_nxt  = param_fill_r;
    param_bytes_nxt = param_bytes_r;
    out_bytes_nxt   = out_bytes_r;
    out_fill_nxt    = out_fill_r;
    dma_count_nxt   = dma_count_r;
    dma_on_nxt      = dma_on_r;
    rate_nxt        = rate_r;
    wide_nxt        = wide_r;
    rd_nxt          = 8'd0;
    op              = cmd_pending_r ? cur_opcode_r : data_r;
    pf              = cmd_pending_r ? param_fill_r : 2'd0;
    moved           = 17'd0;

    unique case (kind_r)
      sdcp_pkg::KIND_WRITE: begin
        if (port_r == sdcp_pkg::PORT_RESET) begin
          cmd_pending_nxt  = 1'b0;
          param_fill_nxt   = 2'd0;
          out_fill_nxt     = FILL_W'(1);
          out_bytes_nxt[0] = audio_ready_r ? sdcp_pkg::AUTODETECT : 8'd0;
        end else if (port_r == sdcp_pkg::PORT_CMD) begin
          cur_opcode_nxt = op;
          if (pf != sdcp_pkg::needed_bytes(op)) begin
            // Still collecting: the opcode itself is stored as the first byte.
            if (pf != 2'd3) param_bytes_nxt[pf] = data_r;
            param_fill_nxt  = pf + 2'd1;
            cmd_pending_nxt = 1'b1;
          end else begin
            param_fill_nxt  = 2'd0;
            cmd_pending_nxt = 1'b0;
            if (op == sdcp_pkg::OP_DMA8) begin
              dma_count_nxt = {1'b0, data_r, param_bytes_r[1]} + 17'd1;
              dma_on_nxt    = 1'b1;
            end else if (op == sdcp_pkg::OP_TIME_CONST) begin
              rate_nxt = sdcp_pkg::snap_rate(data_r);
            end else if (op == sdcp_pkg::OP_HALT) begin
              dma_on_nxt = 1'b0;
            end else if (op == sdcp_pkg::OP_IDENT) begin
              if (out_fill_r < FILL_MAX) begin
                out_bytes_nxt[out_fill_r[IDX_W-1:0]] = ~data_r;
                out_fill_nxt = out_fill_r + FILL_W'(1);
              end
            end else if (op == sdcp_pkg::OP_VERSION) begin
              out_fill_nxt     = FILL_W'(2);
              out_bytes_nxt[0] = 8'd0;
              out_bytes_nxt[1] = 8'd1;
            end else if (op[7:4] == sdcp_pkg::OP_GEN8_HI ||
                         op[7:4] == sdcp_pkg::OP_GEN16_HI) begin
              wide_nxt      = (op[7:4] == sdcp_pkg::OP_GEN16_HI);
              dma_count_nxt = {1'b0, data_r, param_bytes_r[2]} + 17'd1;
              dma_on_nxt    = 1'b1;
            end
          end
        end
      end
      sdcp_pkg::KIND_READ: begin
        if (port_r == sdcp_pkg::PORT_READ) begin
          if (out_fill_r != '0) begin
            out_fill_nxt = pop_pos;
            rd_nxt       = out_bytes_r[pop_pos[IDX_W-1:0]];
          end else begin
            rd_nxt = out_bytes_r[0];
          end
        end else if (port_r == sdcp_pkg::PORT_STATUS) begin
          rd_nxt = (out_fill_r != '0) ? sdcp_pkg::STATUS_READY : 8'd0;
        end
      end
      sdcp_pkg::KIND_DMA: begin
        if (dma_on_r) begin
          moved = ({6'd0, tlen_r} < dma_count_r) ? {6'd0, tlen_r} : dma_count_r;
          dma_count_nxt = dma_count_r - moved;
          if (dma_count_nxt == 17'd0) dma_on_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Requested chunk follows the updated count.
    if (blk_len_r == 11'd0) blk = 11'd1;
    else if (blk_len_r > sdcp_pkg::MAX_BLOCK) blk = sdcp_pkg::MAX_BLOCK;
    else blk = blk_len_r;
    if (!dma_on_nxt) req_nxt = 11'd0;
    else if (dma_count_nxt < {6'd0, blk}) req_nxt = dma_count_nxt[10:0];
    else req_nxt = blk;
  end

  // Item capture and result payload need no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      port_r <= in_port;
      data_r <= in_data;
      tlen_r <= in_transfer_len;
    end
    if (cmd.commit) begin
      rd_r               <= rd_nxt;
      req_r              <= req_nxt;
      param_bytes_r      <= param_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_len_r     <= sdcp_pkg::MAX_BLOCK;
      audio_ready_r <= 1'b1;
      cmd_pending_r <= 1'b0;
      cur_opcode_r  <= 8'd0;
      param_fill_r  <= 2'd0;
      for (int i = 1; i < OUT_DEPTH; i++) out_bytes_r[i] <= 8'd0;
      out_bytes_r[0] <= sdcp_pkg::AUTODETECT;
      out_fill_r    <= FILL_W'(1);
      dma_count_r   <= 17'd0;
      dma_on_r      <= 1'b0;
      rate_r        <= sdcp_pkg::RATE_RESET;
      wide_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sdcp_pkg::CFG_DMA_BLOCK_LEN: blk_len_r     <= cfg_data;
          sdcp_pkg::CFG_AUDIO_READY:   audio_ready_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        cmd_pending_r <= cmd_pending_nxt;
        cur_opcode_r  <= cur_opcode_nxt;
        param_fill_r  <= param_fill_nxt;
        out_bytes_r   <= out_bytes_nxt;
        out_fill_r    <= out_fill_nxt;
        dma_count_r   <= dma_count_nxt;
        dma_on_r      <= dma_on_nxt;
        rate_r        <= rate_nxt;
        wide_r        <= wide_nxt;
      end
    end
  end

  assign out_read_data       = rd_r;
  assign out_dma_active      = dma_on_r;
  assign out_samples_left    = dma_count_r;
  assign out_dma_request_len = req_r;
  assign out_sample_rate     = rate_r;
  assign out_wide_samples    = wide_r;

  `SDCP_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, out_fill_r <= FILL_MAX,
    "out buffer fill count beyond its depth")
  `SDCP_ASSERT_NOW(a_dma_count_live, clk, rst_n, dma_on_r, dma_count_r != 17'd0,
    "DMA enabled with no samples left")
  `SDCP_ASSERT_NOW(a_req_off, clk, rst_n, cmd.commit && !dma_on_nxt, req_nxt == 11'd0,
    "request length nonzero while DMA is off")

endmodule

[hdl/sound_dsp_command_port.sv]
// Top level of the DSP command port: joins the controller and the datapath.
// Depends on sdcp_pkg, sdcp_ctrl, sdcp_dp and the defines header.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   kind, port, data, transfer_len
//   out      output     out_valid/out_stall read_data, dma_active, samples_left,
//                                           dma_request_len, sample_rate,
//                                           wide_samples
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// An item is first captured and then executed through the parser and rate
// snap logic, which then loads the result register.
// The next item is taken while a result waits; execution holds while the
// result register is still full and out_stall is high.
// Reset is synchronous and active low and needs no clearing pass.
module sound_dsp_command_port #(
  parameter int OUT_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [9:0]  in_port,
  input  logic [7:0]  in_data,
  input  logic [10:0] in_transfer_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_dma_active,
  output logic [16:0] out_samples_left,
  output logic [10:0] out_dma_request_len,
  output logic [15:0] out_sample_rate,
  output logic        out_wide_samples,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  sdcp_pkg::ctrl_cmd_t cmd;

  sdcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sdcp_dp #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_kind             (in_kind),
    .in_port             (in_port),
    .in_data             (in_data),
    .in_transfer_len     (in_transfer_len),
    .out_read_data       (out_read_data),
    .out_dma_active      (out_dma_active),
    .out_samples_left    (out_samples_left),
    .out_dma_request_len (out_dma_request_len),
    .out_sample_rate     (out_sample_rate),
    .out_wide_samples    (out_wide_samples)
  );

endmodule
